@@ rtl/core/bsa_pkg.sv @@
// ---------------------------------------------------------------------------
// bsa_pkg
// Shared types, codes and default sizes for the bitmap slab slot allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package bsa_pkg;

    localparam int NUM_BLOCKS_DEF      = 1024;
    localparam int SLOTS_PER_BLOCK_DEF = 60;
    localparam int NUM_QUEUES_DEF      = 256;
    localparam int ROW_REF_BITS_DEF    = 48;

    localparam int QUEUE_FIELD_W = 8;
    localparam int ROW_FIELD_W   = 48;
    localparam int BLOCK_FIELD_W = 10;
    localparam int SLOT_FIELD_W  = 6;
    localparam int STATUS_W      = 2;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_BLOCK = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_USED = 2'd2;

    typedef struct packed {
        logic                     opcode;
        logic [QUEUE_FIELD_W-1:0] queue_index;
        logic [ROW_FIELD_W-1:0]   row_ref;
        logic [BLOCK_FIELD_W-1:0] block_index;
        logic [SLOT_FIELD_W-1:0]  slot_index;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [BLOCK_FIELD_W-1:0] out_block;
        logic [SLOT_FIELD_W-1:0]  out_slot;
    } t_out_item;

    // datapath step commands
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_SWEEP,
        CMD_LOAD,
        CMD_RD_HALF,
        CMD_PICK,
        CMD_TAKE_FREE,
        CMD_CLAIM,
        CMD_RD_BLK,
        CMD_CLEAR,
        CMD_MV_RD,
        CMD_MV_UNLINK,
        CMD_MV_PUSH,
        CMD_MV_FIX
    } t_cmd;

    typedef struct packed {
        t_cmd step;
    } t_dp_ctl;

    typedef struct packed {
        logic                     sweep_last;
        logic                     head_nil;
        logic                     no_slot;
        logic                     now_full;
        logic                     range_bad;
        logic                     bit_clear;
        logic                     was_full;
        logic                     was_one;
        logic [BLOCK_FIELD_W-1:0] blk;
        logic [SLOT_FIELD_W-1:0]  slot;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ rtl/core/bsa_dpath.sv @@
// ---------------------------------------------------------------------------
// bsa_dpath
// Block memories, list links, slot search and the working registers.
// ---------------------------------------------------------------------------
`default_nettype none

module bsa_dpath #(
    parameter int NUM_BLOCKS      = bsa_pkg::NUM_BLOCKS_DEF,
    parameter int SLOTS_PER_BLOCK = bsa_pkg::SLOTS_PER_BLOCK_DEF,
    parameter int NUM_QUEUES      = bsa_pkg::NUM_QUEUES_DEF,
    parameter int ROW_REF_BITS    = bsa_pkg::ROW_REF_BITS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  bsa_pkg::t_in_item  i_in,
    input  bsa_pkg::t_dp_ctl   i_ctl,
    output bsa_pkg::t_dp_stat  o_stat
);
    import bsa_pkg::*;

    localparam int NL      = 1 + 2 * NUM_QUEUES;
    localparam int BI      = $clog2(NUM_BLOCKS);
    localparam int LW      = $clog2(NUM_BLOCKS + 1);
    localparam int SW      = $clog2(SLOTS_PER_BLOCK);
    localparam int QW      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int HW      = $clog2(NL);
    localparam int RDEPTH  = NUM_BLOCKS * SLOTS_PER_BLOCK;
    localparam int RA      = $clog2(RDEPTH);
    localparam int SWEEP_N = (NUM_BLOCKS > NL) ? NUM_BLOCKS : NL;
    localparam int CW      = $clog2(SWEEP_N);
    localparam int QRECIP  = (65536 + NUM_QUEUES - 1) / NUM_QUEUES;
    localparam logic [LW-1:0] NIL = LW'(NUM_BLOCKS);
    localparam logic [SLOTS_PER_BLOCK-1:0] FULL = {SLOTS_PER_BLOCK{1'b1}};

    // memories
    logic [SLOTS_PER_BLOCK-1:0] bm_mem   [NUM_BLOCKS];
    logic [QW-1:0]              qm_mem   [NUM_BLOCKS];
    logic [LW-1:0]              nx_mem   [NUM_BLOCKS];
    logic [LW-1:0]              pv_mem   [NUM_BLOCKS];
    logic [LW-1:0]              hd_mem   [NL];
    logic [ROW_REF_BITS-1:0]    row_mem  [RDEPTH];

    // working registers
    logic [CW-1:0]              r_sweep;
    logic [QW-1:0]              r_q;
    logic [ROW_REF_BITS-1:0]    r_row;
    logic [BI-1:0]              r_b;
    logic [SW-1:0]              r_s;
    logic                       r_range_bad;
    logic [HW-1:0]              r_l1;
    logic [HW-1:0]              r_l2;
    logic [LW-1:0]              r_h;

    // registered read data
    logic [SLOTS_PER_BLOCK-1:0] r_bm_rd;
    logic [QW-1:0]              r_qm_rd;
    logic [LW-1:0]              r_nx_rd;
    logic [LW-1:0]              r_pv_rd;
    logic [LW-1:0]              r_hd_rd;

    logic [23:0]                q_prod;
    logic [7:0]                 q_quo;
    logic [16:0]                q_back;
    logic [QW-1:0]              q_mod;
    logic                       found;
    logic [SW-1:0]              slot_f;
    logic [SLOTS_PER_BLOCK-1:0] claim_bm;
    logic [SLOTS_PER_BLOCK-1:0] clear_bm;
    logic                       head_nil;
    logic                       bit_clear;
    logic                       was_full;
    logic                       was_one;
    logic [HW-1:0]              half_add;
    logic [HW-1:0]              full_add;
    logic [HW-1:0]              half_rm;
    logic [HW-1:0]              full_rm;

    logic [BI-1:0]              bm_ra;
    logic [HW-1:0]              hd_ra;
    logic                       bm_we;
    logic [BI-1:0]              bm_wa;
    logic [SLOTS_PER_BLOCK-1:0] bm_wd;
    logic                       qm_we;
    logic                       row_we;
    logic [RA-1:0]              row_wa;
    logic                       nx_we;
    logic [BI-1:0]              nx_wa;
    logic [LW-1:0]              nx_wd;
    logic                       pv_we;
    logic [BI-1:0]              pv_wa;
    logic [LW-1:0]              pv_wd;
    logic                       hd_we;
    logic [HW-1:0]              hd_wa;
    logic [LW-1:0]              hd_wd;

    // queue index modulo the queue count: reciprocal multiply, exact for 8-bit indices
    always_comb begin
        q_prod = 24'(i_in.queue_index) * 24'(QRECIP);
        q_quo  = q_prod[23:16];
        q_back = 17'(q_quo) * 17'(NUM_QUEUES);
        q_mod  = QW'(17'(i_in.queue_index) - q_back);
    end

    // lowest clear slot
    always_comb begin
        found  = 1'b0;
        slot_f = '0;
        for (int i = SLOTS_PER_BLOCK - 1; i >= 0; i--) begin
            if (!r_bm_rd[i]) begin
                found  = 1'b1;
                slot_f = SW'(i);
            end
        end
    end

    assign claim_bm  = r_bm_rd | (SLOTS_PER_BLOCK'(1) << slot_f);
    assign clear_bm  = r_bm_rd & ~(SLOTS_PER_BLOCK'(1) << r_s);
    assign head_nil  = (r_hd_rd == NIL);
    assign bit_clear = !r_bm_rd[r_s];
    assign was_full  = (r_bm_rd == FULL);
    assign was_one   = ((r_bm_rd & (r_bm_rd - SLOTS_PER_BLOCK'(1))) == '0);
    assign half_add  = HW'(1) + HW'(r_q);
    assign full_add  = HW'(1 + NUM_QUEUES) + HW'(r_q);
    assign half_rm   = HW'(1) + HW'(r_qm_rd);
    assign full_rm   = HW'(1 + NUM_QUEUES) + HW'(r_qm_rd);

    always_comb begin
        bm_ra  = r_b;
        hd_ra  = '0;
        bm_we  = 1'b0;
        bm_wa  = r_b;
        bm_wd  = claim_bm;
        qm_we  = 1'b0;
        row_we = 1'b0;
        row_wa = RA'(32'(r_b) * SLOTS_PER_BLOCK + 32'(slot_f));
        nx_we  = 1'b0;
        nx_wa  = r_b;
        nx_wd  = r_hd_rd;
        pv_we  = 1'b0;
        pv_wa  = r_b;
        pv_wd  = NIL;
        hd_we  = 1'b0;
        hd_wa  = r_l2;
        hd_wd  = LW'(r_b);
        case (i_ctl.step)
            CMD_SWEEP: begin
                bm_we = (32'(r_sweep) < NUM_BLOCKS);
                bm_wa = BI'(r_sweep);
                bm_wd = '0;
                nx_we = (32'(r_sweep) < NUM_BLOCKS);
                nx_wa = BI'(r_sweep);
                nx_wd = LW'(r_sweep) + LW'(1);
                pv_we = (32'(r_sweep) < NUM_BLOCKS);
                pv_wa = BI'(r_sweep);
                pv_wd = (r_sweep == '0) ? NIL : LW'(r_sweep) - LW'(1);
                hd_we = (32'(r_sweep) < NL);
                hd_wa = HW'(r_sweep);
                hd_wd = (r_sweep == '0) ? '0 : NIL;
            end
            CMD_RD_HALF: begin
                hd_ra = half_add;
            end
            CMD_PICK: begin
                bm_ra = BI'(r_hd_rd);
                hd_ra = '0;
            end
            CMD_TAKE_FREE: begin
                bm_we  = !head_nil;
                bm_wa  = BI'(r_hd_rd);
                bm_wd  = SLOTS_PER_BLOCK'(1);
                qm_we  = !head_nil;
                row_we = !head_nil;
                row_wa = RA'(32'(BI'(r_hd_rd)) * SLOTS_PER_BLOCK);
            end
            CMD_CLAIM: begin
                bm_we  = found;
                row_we = found;
            end
            CMD_CLEAR: begin
                bm_we = !bit_clear;
                bm_wd = clear_bm;
            end
            CMD_MV_UNLINK: begin
                hd_ra = r_l2;
                nx_we = (r_pv_rd != NIL);
                nx_wa = BI'(r_pv_rd);
                nx_wd = r_nx_rd;
                hd_we = (r_pv_rd == NIL);
                hd_wa = r_l1;
                hd_wd = r_nx_rd;
                pv_we = (r_nx_rd != NIL);
                pv_wa = BI'(r_nx_rd);
                pv_wd = r_pv_rd;
            end
            CMD_MV_PUSH: begin
                pv_we = 1'b1;
                nx_we = 1'b1;
                hd_we = 1'b1;
            end
            CMD_MV_FIX: begin
                pv_we = (r_h != NIL);
                pv_wa = BI'(r_h);
                pv_wd = LW'(r_b);
            end
            default: begin
            end
        endcase
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        if (bm_we) begin
            bm_mem[bm_wa] <= bm_wd;
        end
        r_bm_rd <= bm_mem[bm_ra];
    end

    always_ff @(posedge i_clk) begin
        if (qm_we) begin
            qm_mem[BI'(r_hd_rd)] <= r_q;
        end
        r_qm_rd <= qm_mem[r_b];
    end

    always_ff @(posedge i_clk) begin
        if (nx_we) begin
            nx_mem[nx_wa] <= nx_wd;
        end
        r_nx_rd <= nx_mem[r_b];
    end

    always_ff @(posedge i_clk) begin
        if (pv_we) begin
            pv_mem[pv_wa] <= pv_wd;
        end
        r_pv_rd <= pv_mem[r_b];
    end

    always_ff @(posedge i_clk) begin
        if (hd_we) begin
            hd_mem[hd_wa] <= hd_wd;
        end
        r_hd_rd <= hd_mem[hd_ra];
    end

    always_ff @(posedge i_clk) begin
        if (row_we) begin
            row_mem[row_wa] <= r_row;
        end
    end

    // sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else if (i_ctl.step == CMD_SWEEP) begin
            r_sweep <= r_sweep + CW'(1);
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_ctl.step)
            CMD_LOAD: begin
                r_q         <= q_mod;
                r_row       <= ROW_REF_BITS'(i_in.row_ref);
                r_b         <= BI'(i_in.block_index);
                r_s         <= SW'(i_in.slot_index);
                r_range_bad <= (32'(i_in.block_index) >= NUM_BLOCKS) ||
                               (32'(i_in.slot_index) >= SLOTS_PER_BLOCK);
            end
            CMD_PICK: begin
                if (!head_nil) begin
                    r_b <= BI'(r_hd_rd);
                end
            end
            CMD_TAKE_FREE: begin
                r_b  <= BI'(r_hd_rd);
                r_s  <= '0;
                r_l1 <= '0;
                r_l2 <= half_add;
            end
            CMD_CLAIM: begin
                r_s  <= slot_f;
                r_l1 <= half_add;
                r_l2 <= full_add;
            end
            CMD_CLEAR: begin
                r_l1 <= was_full ? full_rm : half_rm;
                r_l2 <= was_full ? half_rm : '0;
            end
            CMD_MV_PUSH: begin
                r_h <= r_hd_rd;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_stat.sweep_last = (r_sweep == CW'(SWEEP_N - 1));
        o_stat.head_nil   = head_nil;
        o_stat.no_slot    = !found;
        o_stat.now_full   = (claim_bm == FULL);
        o_stat.range_bad  = r_range_bad;
        o_stat.bit_clear  = bit_clear;
        o_stat.was_full   = was_full;
        o_stat.was_one    = was_one;
        o_stat.blk        = BLOCK_FIELD_W'(r_b);
        o_stat.slot       = SLOT_FIELD_W'(r_s);
    end

endmodule

`default_nettype wire

@@ rtl/core/bsa_ctrl.sv @@
// ---------------------------------------------------------------------------
// bsa_ctrl
// Sequencer for the init sweep, add, remove and list moves; holds the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module bsa_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  bsa_pkg::t_in_item   i_in,
    output logic                o_valid,
    input  wire                 i_stall,
    output bsa_pkg::t_out_item  o_out,
    output bsa_pkg::t_dp_ctl    o_ctl,
    input  bsa_pkg::t_dp_stat   i_stat
);
    import bsa_pkg::*;

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_A_HEAD,
        S_A_PICK,
        S_A_FREE,
        S_A_HALF,
        S_R_RANGE,
        S_R_CHK,
        S_MV_RD,
        S_MV_UNLINK,
        S_MV_PUSH,
        S_MV_FIX,
        S_FIN
    } t_state;

    t_state              r_state;
    logic                r_add;
    logic [STATUS_W-1:0] r_status;
    logic                r_out_valid;
    t_out_item           r_out;

    always_comb begin
        case (r_state)
            S_SWEEP:     o_ctl.step = CMD_SWEEP;
            S_IDLE:      o_ctl.step = i_valid ? CMD_LOAD : CMD_NONE;
            S_A_HEAD:    o_ctl.step = CMD_RD_HALF;
            S_A_PICK:    o_ctl.step = CMD_PICK;
            S_A_FREE:    o_ctl.step = CMD_TAKE_FREE;
            S_A_HALF:    o_ctl.step = CMD_CLAIM;
            S_R_RANGE:   o_ctl.step = CMD_RD_BLK;
            S_R_CHK:     o_ctl.step = CMD_CLEAR;
            S_MV_RD:     o_ctl.step = CMD_MV_RD;
            S_MV_UNLINK: o_ctl.step = CMD_MV_UNLINK;
            S_MV_PUSH:   o_ctl.step = CMD_MV_PUSH;
            S_MV_FIX:    o_ctl.step = CMD_MV_FIX;
            default:     o_ctl.step = CMD_NONE;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_out_valid <= 1'b0;
            r_add       <= 1'b0;
            r_status    <= ST_OK;
        end else begin
            // S_FIN reloads the result register itself
            if (r_out_valid && !i_stall && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_SWEEP: begin
                    if (i_stat.sweep_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_add    <= (i_in.opcode == OP_ADD);
                        r_status <= ST_OK;
                        r_state  <= (i_in.opcode == OP_ADD) ? S_A_HEAD : S_R_RANGE;
                    end
                end
                S_A_HEAD: r_state <= S_A_PICK;
                S_A_PICK: r_state <= i_stat.head_nil ? S_A_FREE : S_A_HALF;
                S_A_FREE: begin
                    if (i_stat.head_nil) begin
                        r_status <= ST_NO_BLOCK;
                        r_state  <= S_FIN;
                    end else begin
                        r_state <= S_MV_RD;
                    end
                end
                S_A_HALF: begin
                    if (i_stat.no_slot) begin
                        r_status <= ST_NO_BLOCK;
                        r_state  <= S_FIN;
                    end else begin
                        r_state <= i_stat.now_full ? S_MV_RD : S_FIN;
                    end
                end
                S_R_RANGE: begin
                    if (i_stat.range_bad) begin
                        r_status <= ST_NOT_USED;
                        r_state  <= S_FIN;
                    end else begin
                        r_state <= S_R_CHK;
                    end
                end
                S_R_CHK: begin
                    if (i_stat.bit_clear) begin
                        r_status <= ST_NOT_USED;
                        r_state  <= S_FIN;
                    end else begin
                        r_state <= (i_stat.was_full || i_stat.was_one) ? S_MV_RD : S_FIN;
                    end
                end
                S_MV_RD:     r_state <= S_MV_UNLINK;
                S_MV_UNLINK: r_state <= S_MV_PUSH;
                S_MV_PUSH:   r_state <= S_MV_FIX;
                S_MV_FIX:    r_state <= S_FIN;
                S_FIN: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid     <= 1'b1;
                        r_out.status    <= r_status;
                        r_out.out_block <= (r_add && r_status == ST_OK) ? i_stat.blk : '0;
                        r_out.out_slot  <= (r_add && r_status == ST_OK) ? i_stat.slot : '0;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/bitmap_slab_slot_allocator.sv @@
// ---------------------------------------------------------------------------
// bitmap_slab_slot_allocator
// Slot allocator over a pool of blocks kept on free, half-full and full lists.
// ---------------------------------------------------------------------------
// One transaction at a time. After reset the block runs an initialisation
// sweep over the blocks and list heads that clears the bitmaps and chains
// the free list; input stall stays high meanwhile. An add that finds room
// in its queue's half-full block claims a slot there; one that starts a
// fresh block, or fills its block, also runs the list move. A remove that
// finds the block or slot out of range stops after the range check, and
// one that changes the block's list also runs the list move. The
// sequencer steps block memories with one read and one write port each:
// bitmap, links and list heads are each read once a cycle with registered
// read data. The result sits in an output register, so a waiting result
// does not hold up the next transaction until that one is ready to finish.
// ---------------------------------------------------------------------------
`default_nettype none

module bitmap_slab_slot_allocator #(
    parameter int NUM_BLOCKS      = bsa_pkg::NUM_BLOCKS_DEF,
    parameter int SLOTS_PER_BLOCK = bsa_pkg::SLOTS_PER_BLOCK_DEF,
    parameter int NUM_QUEUES      = bsa_pkg::NUM_QUEUES_DEF,
    parameter int ROW_REF_BITS    = bsa_pkg::ROW_REF_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  bsa_pkg::t_in_item   i_in,
    output logic                o_valid,
    input  wire                 i_stall,
    output bsa_pkg::t_out_item  o_out
);
    import bsa_pkg::*;

    t_dp_ctl  dp_ctl;   // step command to the datapath
    t_dp_stat dp_stat;  // flags and indices back to the sequencer

    bsa_dpath #(
        .NUM_BLOCKS      (NUM_BLOCKS),
        .SLOTS_PER_BLOCK (SLOTS_PER_BLOCK),
        .NUM_QUEUES      (NUM_QUEUES),
        .ROW_REF_BITS    (ROW_REF_BITS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_ctl   (dp_ctl),
        .o_stat  (dp_stat)
    );

    bsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out),
        .o_ctl   (dp_ctl),
        .i_stat  (dp_stat)
    );

`ifndef NO_ASSERTIONS
    // an accepted transaction closes the input until it completes
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input open right after a transaction was accepted");

    // results with an error status carry no block or slot
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.status != ST_OK) |-> (o_out.out_block == '0 && o_out.out_slot == '0))
        else $error("error result carries a block or slot");

    // a result only appears at the end of work in flight
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared with no transaction in flight");

    // status codes stay within the defined set
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out.status == ST_OK || o_out.status == ST_NO_BLOCK ||
                     o_out.status == ST_NOT_USED))
        else $error("undefined status code");
`endif

endmodule

`default_nettype wire
